### rtl/assert_macros.svh
// Assertion macros for the RTL files; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset
`define ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ealu_pkg.sv
// Package: operation codes and transaction payload types for the eight-bit ALU
`default_nettype none

package ealu_pkg;

    typedef enum logic [4:0] {
        CMD_ADD  = 5'd0,
        CMD_ADC  = 5'd1,
        CMD_SUB  = 5'd2,
        CMD_SBC  = 5'd3,
        CMD_AND  = 5'd4,
        CMD_XOR  = 5'd5,
        CMD_OR   = 5'd6,
        CMD_CP   = 5'd7,
        CMD_INC  = 5'd8,
        CMD_DEC  = 5'd9,
        CMD_RLC  = 5'd10,
        CMD_RRC  = 5'd11,
        CMD_RL   = 5'd12,
        CMD_RR   = 5'd13,
        CMD_SLA  = 5'd14,
        CMD_SRA  = 5'd15,
        CMD_SRL  = 5'd16,
        CMD_SWAP = 5'd17,
        CMD_BIT  = 5'd18,
        CMD_RES  = 5'd19,
        CMD_SET  = 5'd20,
        CMD_DAA  = 5'd21,
        CMD_CPL  = 5'd22,
        CMD_SCF  = 5'd23,
        CMD_CCF  = 5'd24
    } cmd_t;

    localparam logic [7:0] DAA_HI_ADJ   = 8'h60;
    localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
    localparam logic [7:0] DAA_HI_LIMIT = 8'h99;
    localparam logic [3:0] DAA_LO_LIMIT = 4'h9;

    typedef struct packed {
        logic [4:0] cmd;
        logic [7:0] operand_a;
        logic [7:0] operand_b;
        logic [2:0] bit_index;
        logic       check_zero;
        logic       zero_in;
        logic       subtract_in;
        logic       half_in;
        logic       carry_in;
    } in_payload_t;

    typedef struct packed {
        logic [7:0] result_byte;
        logic       zero_out;
        logic       subtract_out;
        logic       half_out;
        logic       carry_out;
    } out_payload_t;

endpackage

`default_nettype wire

### rtl/ealu_core.sv
// Combinational ALU datapath: result byte and flags for one operation
`default_nettype none

module ealu_core
    import ealu_pkg::*;
(
    input  in_payload_t  op_in,
    output out_payload_t op_out
);

    logic [7:0] a;
    logic [7:0] b;
    logic       ci;
    logic       cin;
    logic [8:0] sum9;
    logic [4:0] sum5;
    logic [8:0] diff9;
    logic [4:0] diff5;
    logic [7:0] inc_r;
    logic [7:0] dec_r;
    logic       daa_hi;
    logic       daa_lo;
    logic [7:0] daa_add_r;
    logic [7:0] daa_sub_r;
    logic [7:0] daa_r;
    logic [7:0] bit_mask;
    logic [7:0] r;
    logic       z;
    logic       n;
    logic       h;
    logic       c;

    assign a   = op_in.operand_a;
    assign b   = op_in.operand_b;
    assign ci  = op_in.carry_in;
    assign cin = ci && ((op_in.cmd == CMD_ADC) || (op_in.cmd == CMD_SBC));

    assign sum9  = {1'b0, a} + {1'b0, b} + {8'd0, cin};
    assign sum5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
    assign diff9 = {1'b0, a} - {1'b0, b} - {8'd0, cin};
    assign diff5 = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};

    assign inc_r = a + 8'd1;
    assign dec_r = a - 8'd1;

    assign daa_hi    = ci || (a > DAA_HI_LIMIT);
    assign daa_lo    = op_in.half_in || (a[3:0] > DAA_LO_LIMIT);
    assign daa_add_r = a + (daa_hi ? DAA_HI_ADJ : 8'd0) + (daa_lo ? DAA_LO_ADJ : 8'd0);
    assign daa_sub_r = a - (ci ? DAA_HI_ADJ : 8'd0) - (op_in.half_in ? DAA_LO_ADJ : 8'd0);
    assign daa_r     = op_in.subtract_in ? daa_sub_r : daa_add_r;

    assign bit_mask = 8'd1 << op_in.bit_index;

    always_comb begin
        r = a;
        z = op_in.zero_in;
        n = op_in.subtract_in;
        h = op_in.half_in;
        c = ci;
        case (op_in.cmd)
            CMD_ADD, CMD_ADC: begin
                r = sum9[7:0];
                z = (sum9[7:0] == 8'd0);
                n = 1'b0;
                h = sum5[4];
                c = sum9[8];
            end
            CMD_SUB, CMD_SBC, CMD_CP: begin
                r = (op_in.cmd == CMD_CP) ? a : diff9[7:0];
                z = (diff9[7:0] == 8'd0);
                n = 1'b1;
                h = diff5[4];
                c = diff9[8];
            end
            CMD_AND, CMD_XOR, CMD_OR: begin
                r = (op_in.cmd == CMD_AND) ? (a & b) :
                    (op_in.cmd == CMD_XOR) ? (a ^ b) : (a | b);
                z = (r == 8'd0);
                n = 1'b0;
                h = (op_in.cmd == CMD_AND);
                c = 1'b0;
            end
            CMD_INC: begin
                r = inc_r;
                z = (inc_r == 8'd0);
                n = 1'b0;
                h = (inc_r[3:0] == 4'h0);
            end
            CMD_DEC: begin
                r = dec_r;
                z = (dec_r == 8'd0);
                n = 1'b1;
                h = (dec_r[3:0] == 4'hF);
            end
            CMD_RLC, CMD_RRC, CMD_RL, CMD_RR: begin
                case (op_in.cmd)
                    CMD_RLC: begin
                        r = {a[6:0], a[7]};
                        c = a[7];
                    end
                    CMD_RRC: begin
                        r = {a[0], a[7:1]};
                        c = a[0];
                    end
                    CMD_RL: begin
                        r = {a[6:0], ci};
                        c = a[7];
                    end
                    default: begin
                        r = {ci, a[7:1]};
                        c = a[0];
                    end
                endcase
                z = op_in.check_zero && (r == 8'd0);
                n = 1'b0;
                h = 1'b0;
            end
            CMD_SLA: begin
                r = {a[6:0], 1'b0};
                z = (r == 8'd0);
                n = 1'b0;
                h = 1'b0;
                c = a[7];
            end
            CMD_SRA: begin
                r = {a[7], a[7:1]};
                z = (r == 8'd0);
                n = 1'b0;
                h = 1'b0;
                c = a[0];
            end
            CMD_SRL: begin
                r = {1'b0, a[7:1]};
                z = (r == 8'd0);
                n = 1'b0;
                h = 1'b0;
                c = a[0];
            end
            CMD_SWAP: begin
                r = {a[3:0], a[7:4]};
                z = (a == 8'd0);
                n = 1'b0;
                h = 1'b0;
                c = 1'b0;
            end
            CMD_BIT: begin
                z = !a[op_in.bit_index];
                n = 1'b0;
                h = 1'b1;
            end
            CMD_RES: begin
                r = a & ~bit_mask;
            end
            CMD_SET: begin
                r = a | bit_mask;
            end
            CMD_DAA: begin
                r = daa_r;
                z = (daa_r == 8'd0);
                h = 1'b0;
                c = op_in.subtract_in ? ci : daa_hi;
            end
            CMD_CPL: begin
                r = ~a;
                n = 1'b1;
                h = 1'b1;
            end
            CMD_SCF: begin
                n = 1'b0;
                h = 1'b0;
                c = 1'b1;
            end
            CMD_CCF: begin
                n = 1'b0;
                h = 1'b0;
                c = !ci;
            end
            default: begin
                r = a;
            end
        endcase
    end

    assign op_out.result_byte  = r;
    assign op_out.zero_out     = z;
    assign op_out.subtract_out = n;
    assign op_out.half_out     = h;
    assign op_out.carry_out    = c;

endmodule

`default_nettype wire

### rtl/eight_bit_alu_with_flags_top.sv
// Top level: input register, ALU datapath and result register with valid/ready handshake
// Path: an accepted transaction is held in the input register, then its result in the result register, which drives m_.
// Throughput: one transaction per cycle while m_ready stays high; the input and result registers each advance whenever
// the register behind them is empty or being drained in the same cycle.
// Reset: aresetn is synchronous, active low, and empties both registers; payload is not reset.
`default_nettype none
`include "assert_macros.svh"

module eight_bit_alu_with_flags_top
    import ealu_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [4:0] s_cmd,
    input  wire logic [7:0] s_operand_a,
    input  wire logic [7:0] s_operand_b,
    input  wire logic [2:0] s_bit_index,
    input  wire logic       s_check_zero,
    input  wire logic       s_zero_in,
    input  wire logic       s_subtract_in,
    input  wire logic       s_half_in,
    input  wire logic       s_carry_in,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_result_byte,
    output logic            m_zero_out,
    output logic            m_subtract_out,
    output logic            m_half_out,
    output logic            m_carry_out
);

    in_payload_t  in_reg;
    logic         in_valid_reg;
    logic         in_valid_next;
    out_payload_t out_reg;
    logic         out_valid_reg;
    logic         out_valid_next;
    out_payload_t core_out;
    logic         s_take;
    logic         out_free;
    logic         advance;

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || advance;
    assign s_take   = s_valid && s_ready;

    assign in_valid_next  = s_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_reg.cmd         <= s_cmd;
            in_reg.operand_a   <= s_operand_a;
            in_reg.operand_b   <= s_operand_b;
            in_reg.bit_index   <= s_bit_index;
            in_reg.check_zero  <= s_check_zero;
            in_reg.zero_in     <= s_zero_in;
            in_reg.subtract_in <= s_subtract_in;
            in_reg.half_in     <= s_half_in;
            in_reg.carry_in    <= s_carry_in;
        end
        if (advance) begin
            out_reg <= core_out;
        end
    end

    ealu_core u_core (
        .op_in  (in_reg),
        .op_out (core_out)
    );

    assign m_valid        = out_valid_reg;
    assign m_result_byte  = out_reg.result_byte;
    assign m_zero_out     = out_reg.zero_out;
    assign m_subtract_out = out_reg.subtract_out;
    assign m_half_out     = out_reg.half_out;
    assign m_carry_out    = out_reg.carry_out;

    `ASSERT_NEXT(a_take_fills_input, aclk, aresetn, s_take, in_valid_reg, "accepted transaction lost at input register")
    `ASSERT_NEXT(a_advance_fills_output, aclk, aresetn, advance, out_valid_reg, "advanced transaction lost at result register")
    `ASSERT_NEXT(a_stalled_input_holds, aclk, aresetn, in_valid_reg && !advance, in_valid_reg && $stable(in_reg), "stalled input register changed")
    `ASSERT_NEXT(a_drain_empties, aclk, aresetn, m_valid && m_ready && !in_valid_reg, !m_valid, "result register repeated a transaction")

endmodule

`default_nettype wire
